### rtl/core/ordered_array_insert_remove_find_assert.svh
// Assertion helpers shared by the ordered array store modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_FIND_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_FIND_ASSERT_SVH

// Same-cycle implication.
`define OAF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OAF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/oaf_pkg.sv
package oaf_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_READ   = 3'd3,
    ACT_WRITE  = 3'd4,
    ACT_PUSH   = 3'd5,
    ACT_POP    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_CNT,
    PTR_TGT,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_M1,
    RA_PTR_P1,
    RA_TGT
  } rd_sel_t;

  typedef enum logic {
    WA_PTR,
    WA_TGT
  } wa_sel_t;

  typedef enum logic {
    WS_VAL,
    WS_RAM
  } wd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    cap;
    ptr_op_t ptr_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    cnt_op_t cnt_op;
    logic    hold_rd;
    logic    finish;
    status_t status;
    logic    found;
    logic    rv_ram;
  } oaf_cmd_t;

  typedef struct packed {
    action_t act;
    logic    tgt_gt_cnt;
    logic    tgt_ge_cnt;
    logic    full;
    logic    empty;
    logic    ptr_at_tgt;
    logic    ptr_last;
    logic    ptr_at_cnt;
    logic    match;
  } oaf_stat_t;

endpackage

### rtl/core/ordered_array_insert_remove_find.sv
// Ordered store of signed 32-bit words with a fill count, DEPTH entries in one RAM.
// Input: start/busy command port. A word (in_action, in_position, in_data_value) is
// taken at a rising edge with start high and busy low; busy then stays high until
// the result strobe. Result: out_valid is high for one cycle with all out_* fields;
// the receiver takes it in that cycle and cannot hold it off. A new command may be
// started in the strobe cycle.
// Sequence after the accepting edge (n = count, p = position): errors, write and unused
//   codes finish at decode; read and pop wait for the registered RAM read;
//   insert/push shift entries p..n-1 up, remove shifts entries p+1..n-1 down;
//   find compares entries from 0 upward until one matches or count is reached.
// Shifting and searching go one entry at a time through the single RAM:
// a registered read, then the write or compare.
// Reset (rst_n low, synchronous) empties the store and drops any command in flight;
// entry contents are not cleared and are only read below the count.
module ordered_array_insert_remove_find #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [CNT_W-1:0]   in_position,
  input  logic signed [31:0] in_data_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic               out_found,
  output logic [IDX_W-1:0]   out_found_index,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_is_empty
);

  import oaf_pkg::*;

  oaf_cmd_t  cmd;
  oaf_stat_t stat;

  oaf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  oaf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty)
  );

endmodule

### rtl/core/oaf_ram.sv
module oaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/oaf_ctrl.sv
`include "ordered_array_insert_remove_find_assert.svh"

module oaf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oaf_pkg::oaf_stat_t stat,
  output oaf_pkg::oaf_cmd_t  cmd
);

  import oaf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_FIND_RD,
    S_FIND_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd.cap     = 1'b0;
    cmd.ptr_op  = PTR_HOLD;
    cmd.rd_en   = 1'b0;
    cmd.rd_sel  = RA_PTR;
    cmd.wr_en   = 1'b0;
    cmd.wa_sel  = WA_PTR;
    cmd.wd_sel  = WS_VAL;
    cmd.cnt_op  = CNT_HOLD;
    cmd.hold_rd = 1'b0;
    cmd.finish  = 1'b0;
    cmd.status  = ST_OK;
    cmd.found   = 1'b0;
    cmd.rv_ram  = 1'b0;
    state_nxt   = state_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.act)
          ACT_INSERT, ACT_PUSH: begin
            if (stat.tgt_gt_cnt) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
            end else if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = ST_FULL;
            end else begin
              cmd.ptr_op = PTR_CNT;
              state_nxt  = S_UP_RD;
            end
          end
          ACT_REMOVE: begin
            if (stat.tgt_ge_cnt) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
            end else begin
              cmd.ptr_op = PTR_TGT;
              state_nxt  = S_DN_RD;
            end
          end
          ACT_FIND: begin
            cmd.ptr_op = PTR_ZERO;
            state_nxt  = S_FIND_RD;
          end
          ACT_READ: begin
            if (stat.tgt_ge_cnt) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_TGT;
              state_nxt  = S_RD_WAIT;
            end
          end
          ACT_WRITE: begin
            if (stat.tgt_ge_cnt) begin
              cmd.finish = 1'b1;
              cmd.status = ST_RANGE;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = WA_TGT;
              cmd.wd_sel = WS_VAL;
              cmd.finish = 1'b1;
            end
          end
          ACT_POP: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_TGT;
              cmd.ptr_op = PTR_TGT;
              state_nxt  = S_RD_WAIT;
            end
          end
          default: begin
            // unused action code: no-op
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_RD_WAIT: begin
        if (stat.act == ACT_POP) begin
          cmd.hold_rd = 1'b1;
          state_nxt   = S_DN_RD;
        end else begin
          cmd.rv_ram = 1'b1;
          cmd.finish = 1'b1;
        end
      end
      S_UP_RD: begin
        if (stat.ptr_at_tgt) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_PTR;
          cmd.wd_sel = WS_VAL;
          cmd.cnt_op = CNT_INC;
          cmd.finish = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_M1;
          state_nxt  = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR;
        cmd.wd_sel = WS_RAM;
        cmd.ptr_op = PTR_DEC;
        state_nxt  = S_UP_RD;
      end
      S_DN_RD: begin
        if (stat.ptr_last) begin
          cmd.cnt_op = CNT_DEC;
          cmd.finish = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR_P1;
          state_nxt  = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_PTR;
        cmd.wd_sel = WS_RAM;
        cmd.ptr_op = PTR_INC;
        state_nxt  = S_DN_RD;
      end
      S_FIND_RD: begin
        if (stat.ptr_at_cnt) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PTR;
          state_nxt  = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat.match) begin
          cmd.found  = 1'b1;
          cmd.finish = 1'b1;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_nxt  = S_FIND_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.finish) begin
      state_nxt = S_IDLE;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (cmd.finish) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  `OAF_ASSERT_NXT(a_accept_busy, accept, busy_r, "busy not raised after accept")
  `OAF_ASSERT_NXT(a_finish_idle, cmd.finish, !busy_r, "busy still high after finish")
  `OAF_ASSERT_IMP(a_busy_state, 1'b1, busy_r == (state_r != S_IDLE), "busy out of step")

endmodule

### rtl/core/oaf_dp.sv
`include "ordered_array_insert_remove_find_assert.svh"

module oaf_dp #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  oaf_pkg::oaf_cmd_t  cmd,
  output oaf_pkg::oaf_stat_t stat,
  input  logic [2:0]         in_action,
  input  logic [CNT_W-1:0]   in_position,
  input  logic signed [31:0] in_data_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic               out_found,
  output logic [IDX_W-1:0]   out_found_index,
  output logic [CNT_W-1:0]   out_count,
  output logic               out_is_empty
);

  import oaf_pkg::*;

  action_t            act_r;
  logic [CNT_W-1:0]   pos_r;
  logic signed [31:0] val_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   ptr_inc, ptr_dec, tgt;
  logic [31:0]        rd_r;

  logic [CNT_W-1:0]   raddr_full, waddr_full;
  logic [31:0]        wdata, rdata;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_read_value_r;
  logic               out_found_r;
  logic [IDX_W-1:0]   out_found_index_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_is_empty_r;

  assign ptr_inc = CNT_W'(ptr_r + 1'b1);
  assign ptr_dec = CNT_W'(ptr_r - 1'b1);

  // working index: push appends at count, pop takes count-1
  always_comb begin
    unique case (act_r)
      ACT_PUSH: tgt = cnt_r;
      ACT_POP:  tgt = CNT_W'(cnt_r - 1'b1);
      default:  tgt = pos_r;
    endcase
  end

  assign stat.act        = act_r;
  assign stat.tgt_gt_cnt = tgt > cnt_r;
  assign stat.tgt_ge_cnt = tgt >= cnt_r;
  assign stat.full       = cnt_r == CNT_W'(DEPTH);
  assign stat.empty      = cnt_r == '0;
  assign stat.ptr_at_tgt = ptr_r == tgt;
  assign stat.ptr_last   = ptr_inc == cnt_r;
  assign stat.ptr_at_cnt = ptr_r == cnt_r;
  assign stat.match      = rdata == val_r;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_PTR:    raddr_full = ptr_r;
      RA_PTR_M1: raddr_full = ptr_dec;
      RA_PTR_P1: raddr_full = ptr_inc;
      RA_TGT:    raddr_full = tgt;
    endcase
  end

  assign waddr_full = (cmd.wa_sel == WA_TGT) ? tgt : ptr_r;
  assign wdata      = (cmd.wd_sel == WS_RAM) ? rdata : val_r;

  oaf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr_full[IDX_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr_full[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr_nxt = ptr_r;
      PTR_CNT:  ptr_nxt = cnt_r;
      PTR_TGT:  ptr_nxt = tgt;
      PTR_ZERO: ptr_nxt = '0;
      PTR_INC:  ptr_nxt = ptr_inc;
      PTR_DEC:  ptr_nxt = ptr_dec;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_INC: cnt_nxt = CNT_W'(cnt_r + 1'b1);
      CNT_DEC: cnt_nxt = CNT_W'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.cap) begin
      act_r <= action_t'(in_action);
      pos_r <= in_position;
      val_r <= in_data_value;
      rd_r  <= '0;
    end else if (cmd.hold_rd) begin
      rd_r <= rdata;
    end
    if (cmd.finish) begin
      out_status_r      <= cmd.status;
      out_read_value_r  <= cmd.rv_ram ? rdata : rd_r;
      out_found_r       <= cmd.found;
      out_found_index_r <= cmd.found ? ptr_r[IDX_W-1:0] : '0;
      out_count_r       <= cnt_nxt;
      out_is_empty_r    <= cnt_nxt == '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_is_empty_r;

  `OAF_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(DEPTH), "fill count above depth")
  `OAF_ASSERT_IMP(a_inc_not_full, cmd.cnt_op == CNT_INC, !stat.full, "grow on full store")
  `OAF_ASSERT_IMP(a_found_below, out_valid_r && out_found_r,
    out_found_index_r < out_count_r, "found index not below count")

endmodule
